@@ hw/rtl/line_rasterizer_assert.svh @@
// Assertion macros used by the line rasterizer checker.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define LR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define LR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lr_pkg.sv @@
// Shared types and constants of the line rasterizer.
package lr_pkg;

    // Default coordinate width and command queue depth
    localparam int COORD_BITS_DEF  = 13;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed field widths
    localparam int CFG_W    = 13;
    localparam int PIX_W    = 12;
    localparam int ADDR_W   = 24;
    localparam int COLOR_W  = 32;
    localparam int M_TDATA_W = 2 * PIX_W + ADDR_W + COLOR_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // Action codes carried in s_tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Control flags of one decoded command
    typedef struct packed {
        logic is_load;
        logic busy;
        logic minor_down;
        logic axes_swapped;
    } lr_flags_t;

endpackage

@@ hw/rtl/lr_front.sv @@
// Front end: accepts items and turns load items into line set-up values.
module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input item
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_action,
    input  logic signed [COORD_BITS-1:0]  in_start_x,
    input  logic signed [COORD_BITS-1:0]  in_start_y,
    input  logic signed [COORD_BITS-1:0]  in_end_x,
    input  logic signed [COORD_BITS-1:0]  in_end_y,
    input  logic [lr_pkg::COLOR_W-1:0]    in_color,
    // decoded command towards the queue
    output logic                          cmd_push,
    input  logic                          cmd_full,
    output lr_pkg::lr_flags_t             cmd_flags,
    output logic signed [COORD_BITS-1:0]  cmd_major0,
    output logic signed [COORD_BITS-1:0]  cmd_minor0,
    output logic signed [COORD_BITS-1:0]  cmd_limit,
    output logic [COORD_BITS:0]           cmd_twice_major,
    output logic [COORD_BITS:0]           cmd_twice_minor,
    output logic [COORD_BITS-1:0]         cmd_err_init,
    output logic [lr_pkg::COLOR_W-1:0]    cmd_color
);

    localparam int CB = COORD_BITS;

    // stage A: steepness and axis swap
    logic signed [CB:0]   dx_a, dy_a;
    logic [CB:0]          adx_full, ady_full;
    logic                 steep_a;

    logic                 fa_valid_reg, fa_valid_next;
    logic                 fa_load_reg;
    logic                 fa_steep_reg;
    logic signed [CB-1:0] fa_a0_reg, fa_b0_reg, fa_a1_reg, fa_b1_reg;
    logic [lr_pkg::COLOR_W-1:0] fa_color_reg;

    // stage B: endpoint order and deltas
    logic                 swap_b;
    logic signed [CB-1:0] maj0_b, min0_b, lim_b, min1_b;
    logic signed [CB:0]   dmaj_b, dmin_b;
    logic [CB:0]          admin_full;
    logic [CB-1:0]        dmaj_u, dmin_u;

    assign in_ready = !fa_valid_reg || !cmd_full;
    assign cmd_push = fa_valid_reg && !cmd_full;

    // Work out absolute deltas and steepness of the raw endpoints
    always_comb begin
        dx_a     = $signed({in_end_x[CB-1], in_end_x}) - $signed({in_start_x[CB-1], in_start_x});
        dy_a     = $signed({in_end_y[CB-1], in_end_y}) - $signed({in_start_y[CB-1], in_start_y});
        adx_full = dx_a[CB] ? $unsigned(-dx_a) : $unsigned(dx_a);
        ady_full = dy_a[CB] ? $unsigned(-dy_a) : $unsigned(dy_a);
        steep_a  = ady_full[CB-1:0] > adx_full[CB-1:0];
    end

    // Hold stage A until the queue takes it
    always_comb begin
        fa_valid_next = fa_valid_reg;
        if (in_ready) begin
            fa_valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fa_valid_reg <= 1'b0;
        end else begin
            fa_valid_reg <= fa_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            fa_load_reg  <= (in_action == lr_pkg::ACT_LOAD);
            fa_steep_reg <= steep_a;
            fa_a0_reg    <= steep_a ? in_start_y : in_start_x;
            fa_b0_reg    <= steep_a ? in_start_x : in_start_y;
            fa_a1_reg    <= steep_a ? in_end_y   : in_end_x;
            fa_b1_reg    <= steep_a ? in_end_x   : in_end_y;
            fa_color_reg <= in_color;
        end
    end

    // Order the endpoints so the major coordinate rises
    always_comb begin
        swap_b     = fa_a0_reg > fa_a1_reg;
        maj0_b     = swap_b ? fa_a1_reg : fa_a0_reg;
        min0_b     = swap_b ? fa_b1_reg : fa_b0_reg;
        lim_b      = swap_b ? fa_a0_reg : fa_a1_reg;
        min1_b     = swap_b ? fa_b0_reg : fa_b1_reg;
        dmaj_b     = $signed({lim_b[CB-1], lim_b}) - $signed({maj0_b[CB-1], maj0_b});
        dmin_b     = $signed({min1_b[CB-1], min1_b}) - $signed({min0_b[CB-1], min0_b});
        admin_full = dmin_b[CB] ? $unsigned(-dmin_b) : $unsigned(dmin_b);
        dmaj_u     = dmaj_b[CB-1:0];
        dmin_u     = admin_full[CB-1:0];
    end

    assign cmd_flags.is_load      = fa_load_reg;
    assign cmd_flags.busy         = maj0_b < lim_b;
    assign cmd_flags.minor_down   = !(min0_b < min1_b);
    assign cmd_flags.axes_swapped = fa_steep_reg;
    assign cmd_major0      = maj0_b;
    assign cmd_minor0      = min0_b;
    assign cmd_limit       = lim_b;
    assign cmd_twice_major = {dmaj_u, 1'b0};
    assign cmd_twice_minor = {dmin_u, 1'b0};
    assign cmd_err_init    = dmaj_u;
    assign cmd_color       = fa_color_reg;

endmodule

@@ hw/rtl/lr_queue.sv @@
// Short command queue between the front end and the step engine.
module lr_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = lr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [DATA_W-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/lr_back.sv @@
// Step engine: Bresenham state, clipping, address multiply and output register.
module lr_back #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // decoded command from the queue
    input  logic                              cmd_valid,
    output logic                              cmd_pop,
    input  lr_pkg::lr_flags_t                 cmd_flags,
    input  logic signed [COORD_BITS-1:0]      cmd_major0,
    input  logic signed [COORD_BITS-1:0]      cmd_minor0,
    input  logic signed [COORD_BITS-1:0]      cmd_limit,
    input  logic [COORD_BITS:0]               cmd_twice_major,
    input  logic [COORD_BITS:0]               cmd_twice_minor,
    input  logic [COORD_BITS-1:0]             cmd_err_init,
    input  logic [lr_pkg::COLOR_W-1:0]        cmd_color,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lr_pkg::CFG_W-1:0]          cfg_data,
    // result
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lr_pkg::M_TDATA_W-1:0]      out_data,
    output logic                              out_pixel_valid,
    output logic                              out_line_done
);

    localparam int CB   = COORD_BITS;
    localparam int ERRW = CB + 3;
    localparam int CMPW = (CB > lr_pkg::CFG_W) ? CB : lr_pkg::CFG_W;
    localparam int MULW = CB + lr_pkg::CFG_W;

    // configuration registers
    logic [lr_pkg::CFG_W-1:0] width_reg, height_reg;

    // line state
    logic signed [CB-1:0]   major_reg, major_next;
    logic signed [CB-1:0]   minor_reg, minor_next;
    logic signed [CB-1:0]   limit_reg, limit_next;
    logic signed [ERRW-1:0] err_reg, err_next;
    logic [CB:0]            tmaj_reg, tmaj_next;
    logic [CB:0]            tmin_reg, tmin_next;
    logic                   down_reg, down_next;
    logic                   swap_reg, swap_next;
    logic [lr_pkg::COLOR_W-1:0] color_reg, color_next;
    logic                   busy_reg, busy_next;

    // step arithmetic
    logic signed [CB-1:0]   px_s, py_s;
    logic                   vis_s;
    logic signed [ERRW-1:0] err_sub;
    logic signed [CB:0]     maj_inc, lim_ext;

    // stage 1: clipped pixel
    logic                   s1_valid_reg, s1_valid_next;
    logic                   s1_vis_reg, s1_vis_next;
    logic                   s1_done_reg, s1_done_next;
    logic [CB-1:0]          s1_px_reg, s1_py_reg;
    logic [lr_pkg::COLOR_W-1:0] s1_color_reg;
    logic                   s1_ready, s2_ready;

    // stage 2: output register
    logic                   out_valid_reg, out_valid_next;
    logic [lr_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                   out_pix_reg, out_done_reg;
    logic [MULW-1:0]        addr_full;

    assign s2_ready  = !out_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign cmd_pop   = cmd_valid && s1_ready;
    assign cfg_ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lr_pkg::SCREEN_WIDTH_RST;
            height_reg <= lr_pkg::SCREEN_HEIGHT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                lr_pkg::REG_SCREEN_WIDTH: begin
                    width_reg <= cfg_data;
                end
                lr_pkg::REG_SCREEN_HEIGHT: begin
                    height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Pixel at the current position and its clip test
    always_comb begin
        px_s  = swap_reg ? minor_reg : major_reg;
        py_s  = swap_reg ? major_reg : minor_reg;
        vis_s = !px_s[CB-1] && (CMPW'($unsigned(px_s)) < CMPW'(width_reg)) &&
                !py_s[CB-1] && (CMPW'($unsigned(py_s)) < CMPW'(height_reg));
        err_sub = err_reg - $signed(ERRW'(tmin_reg));
        maj_inc = $signed({major_reg[CB-1], major_reg}) + $signed((CB+1)'(1));
        lim_ext = $signed({limit_reg[CB-1], limit_reg});
    end

    // Load a line, or advance one pixel on each step taken while the line is busy
    always_comb begin
        major_next    = major_reg;
        minor_next    = minor_reg;
        limit_next    = limit_reg;
        err_next      = err_reg;
        tmaj_next     = tmaj_reg;
        tmin_next     = tmin_reg;
        down_next     = down_reg;
        swap_next     = swap_reg;
        color_next    = color_reg;
        busy_next     = busy_reg;
        s1_valid_next = s1_valid_reg;
        s1_vis_next   = 1'b0;
        s1_done_next  = 1'b1;
        if (s1_ready) begin
            s1_valid_next = cmd_valid;
        end
        if (cmd_pop) begin
            if (cmd_flags.is_load) begin
                major_next   = cmd_major0;
                minor_next   = cmd_minor0;
                limit_next   = cmd_limit;
                err_next     = $signed(ERRW'(cmd_err_init));
                tmaj_next    = cmd_twice_major;
                tmin_next    = cmd_twice_minor;
                down_next    = cmd_flags.minor_down;
                swap_next    = cmd_flags.axes_swapped;
                color_next   = cmd_color;
                busy_next    = cmd_flags.busy;
                s1_done_next = !cmd_flags.busy;
            end else if (busy_reg) begin
                s1_vis_next = vis_s;
                if (err_sub[ERRW-1]) begin
                    minor_next = down_reg ? minor_reg - CB'(1) : minor_reg + CB'(1);
                    err_next   = err_sub + $signed(ERRW'(tmaj_reg));
                end else begin
                    err_next   = err_sub;
                end
                major_next   = maj_inc[CB-1:0];
                busy_next    = maj_inc < lim_ext;
                s1_done_next = !(maj_inc < lim_ext);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            major_reg    <= '0;
            minor_reg    <= '0;
            limit_reg    <= '0;
            err_reg      <= '0;
            tmaj_reg     <= '0;
            tmin_reg     <= '0;
            down_reg     <= 1'b0;
            swap_reg     <= 1'b0;
            color_reg    <= '0;
            busy_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            limit_reg    <= limit_next;
            err_reg      <= err_next;
            tmaj_reg     <= tmaj_next;
            tmin_reg     <= tmin_next;
            down_reg     <= down_next;
            swap_reg     <= swap_next;
            color_reg    <= color_next;
            busy_reg     <= busy_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Hold the clipped pixel for the address stage
    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            s1_vis_reg   <= s1_vis_next;
            s1_done_reg  <= s1_done_next;
            s1_px_reg    <= $unsigned(px_s);
            s1_py_reg    <= $unsigned(py_s);
            s1_color_reg <= color_reg;
        end
    end

    // Linear address: row times stride plus column
    assign addr_full = MULW'(s1_py_reg) * MULW'(width_reg) + MULW'(s1_px_reg);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (s2_ready) begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Register the result; blank the pixel fields when nothing is drawn
    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            out_pix_reg  <= s1_vis_reg;
            out_done_reg <= s1_done_reg;
            if (s1_vis_reg) begin
                out_data_reg <= {s1_color_reg, lr_pkg::ADDR_W'(addr_full),
                                 lr_pkg::PIX_W'(s1_py_reg), lr_pkg::PIX_W'(s1_px_reg)};
            end else begin
                out_data_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign out_pixel_valid = out_pix_reg;
    assign out_line_done   = out_done_reg;

endmodule

@@ hw/rtl/line_rasterizer.sv @@
// Top level of the line rasterizer: front end, command queue and step engine.
//
//   channel   direction  transfer when           carries
//   s_        in         s_tvalid & s_tready     load or step item
//   m_        out        m_tvalid & m_tready     one result per item
//   cfg_      in         cfg_valid & cfg_ready   screen width / height write
//
// One item per cycle sustained while m_ is not stalled. An item passes the front
// register, the queue entry, the pixel stage and the output register before its
// result is presented on m_. The Bresenham update is an add, compare and select
// on the line state, which sets the rate of one pixel per clock.
// aresetn is synchronous: it empties the queue, clears the line state and
// restores 640 x 480. A stalled m_ side fills the queue, then drops s_tready.
module line_rasterizer #(
    parameter int COORD_BITS  = lr_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF,
    localparam int S_TDATA_W  = ((4 * COORD_BITS + lr_pkg::COLOR_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_x, start_y, end_x, end_y, draw_color, zero pad
    input  logic [S_TDATA_W-1:0]           s_tdata,
    // action
    input  logic                           s_tuser,
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel_x, pixel_y, pixel_address, pixel_color
    output logic [lr_pkg::M_TDATA_W-1:0]   m_tdata,
    // pixel_valid
    output logic                           m_tuser,
    // line_done
    output logic                           m_tlast,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lr_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CB      = COORD_BITS;
    localparam int FLAGS_W = $bits(lr_pkg::lr_flags_t);
    localparam int ENTRY_W = FLAGS_W + 4 * CB + 2 * (CB + 1) + lr_pkg::COLOR_W;

    lr_pkg::lr_flags_t            f_flags, b_flags;
    logic                         f_push, q_full, q_valid, b_pop;
    logic signed [CB-1:0]         f_major0, f_minor0, f_limit;
    logic signed [CB-1:0]         b_major0, b_minor0, b_limit;
    logic [CB:0]                  f_tmaj, f_tmin, b_tmaj, b_tmin;
    logic [CB-1:0]                f_err, b_err;
    logic [lr_pkg::COLOR_W-1:0]   f_color, b_color;
    logic [ENTRY_W-1:0]           q_in, q_out;

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_action       (s_tuser),
        .in_start_x      ($signed(s_tdata[CB-1:0])),
        .in_start_y      ($signed(s_tdata[2*CB-1:CB])),
        .in_end_x        ($signed(s_tdata[3*CB-1:2*CB])),
        .in_end_y        ($signed(s_tdata[4*CB-1:3*CB])),
        .in_color        (s_tdata[4*CB+lr_pkg::COLOR_W-1:4*CB]),
        .cmd_push        (f_push),
        .cmd_full        (q_full),
        .cmd_flags       (f_flags),
        .cmd_major0      (f_major0),
        .cmd_minor0      (f_minor0),
        .cmd_limit       (f_limit),
        .cmd_twice_major (f_tmaj),
        .cmd_twice_minor (f_tmin),
        .cmd_err_init    (f_err),
        .cmd_color       (f_color)
    );

    // Pack a decoded command into one queue entry
    assign q_in = {f_flags, f_major0, f_minor0, f_limit, f_tmaj, f_tmin, f_err, f_color};

    lr_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (b_pop),
        .head_valid (q_valid),
        .head_data  (q_out)
    );

    assign {b_flags, b_major0, b_minor0, b_limit, b_tmaj, b_tmin, b_err, b_color} = q_out;

    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (q_valid),
        .cmd_pop         (b_pop),
        .cmd_flags       (b_flags),
        .cmd_major0      (b_major0),
        .cmd_minor0      (b_minor0),
        .cmd_limit       (b_limit),
        .cmd_twice_major (b_tmaj),
        .cmd_twice_minor (b_tmin),
        .cmd_err_init    (b_err),
        .cmd_color       (b_color),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_data        (m_tdata),
        .out_pixel_valid (m_tuser),
        .out_line_done   (m_tlast)
    );

endmodule

@@ hw/rtl/lr_checker.sv @@
// Port-level checks on the rasterizer result channel, bound to the top level.
`include "line_rasterizer_assert.svh"

module lr_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                         m_tuser,
    input logic                         m_tlast
);

    // hold a result the sink has not yet taken
    `LR_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // results without a drawn pixel carry all-zero pixel fields
    `LR_ASSERT_SAME(a_blank_when_hidden, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0, "hidden pixel has non-zero fields")

    // reset empties the result register
    `LR_ASSERT_NEXT(a_reset_empties, aclk, 1'b1, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind line_rasterizer lr_checker u_lr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ dv/line_rasterizer_tb.sv @@
// Self-checking testbench for the line rasterizer: Bresenham prediction, scoreboard, stream drivers.
`timescale 1ns / 1ps

typedef logic signed [lr_pkg::COORD_BITS_DEF-1:0] coord_t;

// One input item as it travels on s_tuser / s_tdata
typedef struct {
    logic        action;
    coord_t      x0;
    coord_t      y0;
    coord_t      x1;
    coord_t      y1;
    logic [31:0] color;
} line_cmd_t;

// One result item as it travels on m_tuser / m_tdata / m_tlast
typedef struct {
    logic                        vis;
    logic [lr_pkg::PIX_W-1:0]    px;
    logic [lr_pkg::PIX_W-1:0]    py;
    logic [lr_pkg::ADDR_W-1:0]   addr;
    logic [lr_pkg::COLOR_W-1:0]  color;
    logic                        done;
} pixel_t;

function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
endfunction

// Tracks the line state and the screen size, and holds the pixels still owed
class raster_tracker;
    pixel_t                   pending_pixels[$];
    int unsigned              mismatches;
    logic [lr_pkg::CFG_W-1:0] width_reg;
    logic [lr_pkg::CFG_W-1:0] height_reg;
    coord_t                   major_pos;
    coord_t                   minor_pos;
    coord_t                   major_limit;
    logic signed [15:0]       error_acc;
    logic [14:0]              twice_major;
    logic [14:0]              twice_minor;
    logic                     minor_down;
    logic                     axes_swapped;
    logic                     busy;
    logic [31:0]              line_color;

    function new();
        mismatches   = 0;
        width_reg    = lr_pkg::SCREEN_WIDTH_RST;
        height_reg   = lr_pkg::SCREEN_HEIGHT_RST;
        major_pos    = '0;
        minor_pos    = '0;
        major_limit  = '0;
        error_acc    = '0;
        twice_major  = '0;
        twice_minor  = '0;
        minor_down   = 1'b0;
        axes_swapped = 1'b0;
        busy         = 1'b0;
        line_color   = '0;
    endfunction

    function void set_register(input logic [lr_pkg::CFG_IDX_W-1:0] idx,
                               input logic [lr_pkg::CFG_W-1:0] val);
        if (idx == lr_pkg::REG_SCREEN_WIDTH) begin
            width_reg = val;
        end else begin
            height_reg = val;
        end
    endfunction

    // Work out the pixel that one accepted item owes and advance the line
    function void take_item(input line_cmd_t c);
        pixel_t p;
        int     ax, ay, bx, by, t, px, py;
        logic   steep;
        p = '{vis: 1'b0, px: '0, py: '0, addr: '0, color: '0, done: 1'b0};
        if (c.action == lr_pkg::ACT_LOAD) begin
            ax = c.x0;
            ay = c.y0;
            bx = c.x1;
            by = c.y1;
            // swap axes for steep lines, then order so the major coordinate rises
            steep = magnitude(by - ay) > magnitude(bx - ax);
            if (steep) begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            major_pos    = ax[lr_pkg::COORD_BITS_DEF-1:0];
            minor_pos    = ay[lr_pkg::COORD_BITS_DEF-1:0];
            major_limit  = bx[lr_pkg::COORD_BITS_DEF-1:0];
            t            = 2 * (bx - ax);
            twice_major  = t[14:0];
            t            = 2 * magnitude(by - ay);
            twice_minor  = t[14:0];
            t            = bx - ax;
            error_acc    = t[15:0];
            minor_down   = !(ay < by);
            axes_swapped = steep;
            line_color   = c.color;
            busy         = ax < bx;
            p.done       = !busy;
        end else if (!busy) begin
            p.done = 1'b1;
        end else begin
            px = axes_swapped ? minor_pos : major_pos;
            py = axes_swapped ? major_pos : minor_pos;
            // clip to the screen; off-screen steps still advance
            if (px >= 0 && px < int'(width_reg) && py >= 0 && py < int'(height_reg)) begin
                p.vis   = 1'b1;
                p.px    = px[lr_pkg::PIX_W-1:0];
                p.py    = py[lr_pkg::PIX_W-1:0];
                t       = px + py * int'(width_reg);
                p.addr  = t[lr_pkg::ADDR_W-1:0];
                p.color = line_color;
            end
            // doubled error term: move the minor axis when it goes negative
            t = int'(error_acc) - int'(twice_minor);
            if (t < 0) begin
                px        = int'(minor_pos) + (minor_down ? -1 : 1);
                minor_pos = px[lr_pkg::COORD_BITS_DEF-1:0];
                t         = t + int'(twice_major);
            end
            error_acc = t[15:0];
            px        = int'(major_pos) + 1;
            major_pos = px[lr_pkg::COORD_BITS_DEF-1:0];
            busy      = major_pos < major_limit;
            p.done    = !busy;
        end
        pending_pixels.push_back(p);
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare one result transfer with the oldest owed pixel
    function void match_pixel(input pixel_t got);
        pixel_t want;
        if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected none, got valid=%0b x=%0d y=%0d done=%0b",
                     $time, got.vis, got.px, got.py, got.done);
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        check_field("pixel_valid", 32'(want.vis), 32'(got.vis));
        check_field("pixel_x", 32'(want.px), 32'(got.px));
        check_field("pixel_y", 32'(want.py), 32'(got.py));
        check_field("pixel_address", 32'(want.addr), 32'(got.addr));
        check_field("pixel_color", want.color, got.color);
        check_field("line_done", 32'(want.done), 32'(got.done));
    endfunction
endclass

module line_rasterizer_tb;

    localparam int S_TDATA_W      = ((4 * lr_pkg::COORD_BITS_DEF + lr_pkg::COLOR_W + 7) / 8) * 8;
    localparam int COORD_MAX      = (1 << (lr_pkg::COORD_BITS_DEF - 1)) - 1;
    localparam int COORD_MIN      = -(1 << (lr_pkg::COORD_BITS_DEF - 1));
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 140;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_STEPS      = 60;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [S_TDATA_W-1:0]          s_tdata   = '0;
    logic                          s_tuser   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [lr_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [lr_pkg::CFG_IDX_W-1:0]  cfg_index = lr_pkg::REG_SCREEN_WIDTH;
    logic [lr_pkg::CFG_W-1:0]      cfg_data  = '0;

    raster_tracker tracker;
    pixel_t        seen_pixel;
    int            feed_gap_pct    = 25;
    int            drain_stall_pct = 25;
    int            stall_left      = 0;
    int            quiet_cycles    = 0;
    int            items_sent      = 0;

    line_rasterizer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic coord_t fit_coord(input int v);
        if (v > COORD_MAX) begin
            v = COORD_MAX;
        end
        if (v < COORD_MIN) begin
            v = COORD_MIN;
        end
        return v[lr_pkg::COORD_BITS_DEF-1:0];
    endfunction

    // A coordinate around the visible span, straddling both edges
    function automatic coord_t near_coord(input int span);
        return fit_coord(int'($urandom_range(0, span + 32)) - 16);
    endfunction

    // Receive results, stalling m_tready at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_pixel.vis   = m_tuser;
                seen_pixel.px    = m_tdata[11:0];
                seen_pixel.py    = m_tdata[23:12];
                seen_pixel.addr  = m_tdata[47:24];
                seen_pixel.color = m_tdata[79:48];
                seen_pixel.done  = m_tlast;
                tracker.match_pixel(seen_pixel);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap(drain_stall_pct);
                m_tready   <= (stall_left == 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    // Abort when no transfer of any kind happens for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[line_rasterizer] ERROR");
                $finish;
            end
        end
    end

    // Present one item after a random gap and hold it until the transfer
    task automatic send_item(input line_cmd_t c);
        int gap;
        gap = pick_gap(feed_gap_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.action;
        s_tdata  <= S_TDATA_W'({c.color, c.y1, c.x1, c.y0, c.x0});
        do @(posedge aclk); while (!s_tready);
        tracker.take_item(c);
        items_sent++;
    endtask

    task automatic send_load(input int x0, input int y0, input int x1, input int y1,
                             input logic [31:0] color);
        line_cmd_t c;
        c.action = lr_pkg::ACT_LOAD;
        c.x0     = fit_coord(x0);
        c.y0     = fit_coord(y0);
        c.x1     = fit_coord(x1);
        c.y1     = fit_coord(y1);
        c.color  = color;
        send_item(c);
    endtask

    // Step items carry junk in the unused data fields
    task automatic send_steps(input int n);
        line_cmd_t c;
        repeat (n) begin
            c.action = lr_pkg::ACT_STEP;
            c.x0     = fit_coord(int'($urandom_range(0, 8191)) + COORD_MIN);
            c.y0     = fit_coord(int'($urandom_range(0, 8191)) + COORD_MIN);
            c.x1     = fit_coord(int'($urandom_range(0, 8191)) + COORD_MIN);
            c.y1     = fit_coord(int'($urandom_range(0, 8191)) + COORD_MIN);
            c.color  = $urandom;
            send_item(c);
        end
    endtask

    // Drop s_tvalid and wait until every owed pixel has come back
    task automatic flush_pixels();
        s_tvalid <= 1'b0;
        while (tracker.pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // Write both screen registers back to back, holding cfg_valid between them
    task automatic set_screen(input int w, input int h);
        cfg_valid <= 1'b1;
        cfg_index <= lr_pkg::REG_SCREEN_WIDTH;
        cfg_data  <= w[lr_pkg::CFG_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_register(lr_pkg::REG_SCREEN_WIDTH, w[lr_pkg::CFG_W-1:0]);
        cfg_index <= lr_pkg::REG_SCREEN_HEIGHT;
        cfg_data  <= h[lr_pkg::CFG_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_register(lr_pkg::REG_SCREEN_HEIGHT, h[lr_pkg::CFG_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // One load followed by roughly enough steps to finish the line
    task automatic random_line(input int w, input int h);
        line_cmd_t c;
        int        len, major, steps, span_x, span_y, shape;
        span_x = (w > COORD_MAX) ? COORD_MAX : w;
        span_y = (h > COORD_MAX) ? COORD_MAX : h;
        feed_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
        drain_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
        shape = $urandom_range(0, 7);
        if (shape == 0) begin
            c.x0 = fit_coord(int'($urandom_range(0, 8191)) + COORD_MIN);
            c.y0 = fit_coord(int'($urandom_range(0, 8191)) + COORD_MIN);
            c.x1 = fit_coord(int'($urandom_range(0, 8191)) + COORD_MIN);
            c.y1 = fit_coord(int'($urandom_range(0, 8191)) + COORD_MIN);
        end else begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
            c.x0 = near_coord(span_x);
            c.y0 = near_coord(span_y);
            c.x1 = fit_coord(int'(c.x0) + int'($urandom_range(0, 2 * len)) - len);
            c.y1 = fit_coord(int'(c.y0) + int'($urandom_range(0, 2 * len)) - len);
            // horizontal and vertical lines
            if (shape == 1) begin
                c.y1 = c.y0;
            end else if (shape == 2) begin
                c.x1 = c.x0;
            end
        end
        c.action = lr_pkg::ACT_LOAD;
        c.color  = $urandom;
        send_item(c);
        major = magnitude(int'(c.x1) - int'(c.x0));
        if (magnitude(int'(c.y1) - int'(c.y0)) > major) begin
            major = magnitude(int'(c.y1) - int'(c.y0));
        end
        steps = major + $urandom_range(0, 2);
        // cut some lines short so the next load abandons them
        if ($urandom_range(0, 7) == 0 || steps > MAX_STEPS) begin
            steps = $urandom_range(0, (steps > MAX_STEPS) ? MAX_STEPS : steps);
        end
        send_steps(steps);
    endtask

    int phase_w[NUM_PHASES] = '{1, 4096, 0, 64, -1, -1, -1, 4096};
    int phase_h[NUM_PHASES] = '{1, 4096, 0, 48, -1, -1, -1, 1};

    initial begin
        int w, h, first;
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines on the reset screen of 640 x 480
        send_steps(1);
        send_load(5, 5, 5, 5, 32'h0000_0000);
        send_steps(1);
        send_load(0, 0, 4, 2, 32'hFFFF_FFFF);
        send_steps(5);
        // steep and descending, abandoned part way by the next load
        send_load(3, 20, 6, 12, 32'h1234_5678);
        send_steps(3);
        // horizontal across the left edge
        send_load(-2, 7, 3, 7, 32'h00FF_00FF);
        send_steps(5);
        // vertical across the bottom edge
        send_load(639, 478, 639, 481, 32'hFF00_FF00);
        send_steps(3);
        // coordinate extremes, both diagonals
        send_load(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'hA5A5_5A5A);
        send_steps(1);
        send_load(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32'h5A5A_A5A5);
        send_steps(1);
        flush_pixels();

        // Random lines under a series of screen sizes
        for (int i = 0; i < NUM_PHASES; i++) begin
            w = (phase_w[i] < 0) ? $urandom_range(1, 4096) : phase_w[i];
            h = (phase_h[i] < 0) ? $urandom_range(1, 4096) : phase_h[i];
            set_screen(w, h);
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS) begin
                random_line(w, h);
            end
            flush_pixels();
        end

        // Let any stray result show up before judging
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0) begin
            $display("[line_rasterizer] OK");
        end else begin
            $display("[line_rasterizer] ERROR");
        end
        $finish;
    end

endmodule
